>>> src/pnp_prs_pkg.sv
// ----------------------------------------------------------------------------
// pnp_prs_pkg: shared types, codes and helpers of the resource parser.
// Holds record kinds, phase codes, the serial LFSR step and the tag decoder.
// ----------------------------------------------------------------------------
package pnp_prs_pkg;

  localparam int StoreDepth = 17;

  localparam logic [4:0] K_HEADER   = 5'd0;
  localparam logic [4:0] K_VERSION  = 5'd1;
  localparam logic [4:0] K_LOGID    = 5'd2;
  localparam logic [4:0] K_COMPAT   = 5'd3;
  localparam logic [4:0] K_IRQ      = 5'd4;
  localparam logic [4:0] K_DMA      = 5'd5;
  localparam logic [4:0] K_STARTDEP = 5'd6;
  localparam logic [4:0] K_ENDDEP   = 5'd7;
  localparam logic [4:0] K_IO       = 5'd8;
  localparam logic [4:0] K_FIXEDIO  = 5'd9;
  localparam logic [4:0] K_VENDOR   = 5'd10;
  localparam logic [4:0] K_ANSI     = 5'd11;
  localparam logic [4:0] K_UNICODE  = 5'd12;
  localparam logic [4:0] K_MEM      = 5'd13;
  localparam logic [4:0] K_MEM32    = 5'd14;
  localparam logic [4:0] K_FMEM32   = 5'd15;
  localparam logic [4:0] K_END      = 5'd16;
  localparam logic [4:0] K_CSUM_ERR = 5'd17;
  localparam logic [4:0] K_UNKNOWN  = 5'd18;

  localparam logic [2:0] PH_SERIAL = 3'd0;
  localparam logic [2:0] PH_TAG    = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_HALT   = 3'd5;

  localparam logic [7:0] LfsrSeed = 8'h6A;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  flags;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [31:0] value_d;
    logic        has_byte;
    logic        last;
  } rec_t;

  // Eight serial bits shifted in LSB first.
  function automatic logic [7:0] lfsr_byte(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = {r[0] ^ r[1] ^ d[i], r[7:1]};
    end
    return r;
  endfunction

  function automatic logic [4:0] kind_of(input logic [7:0] h);
    logic [4:0] k;
    k = K_UNKNOWN;
    if (!h[7]) begin
      unique case (h[6:3])
        4'd1:    k = K_VERSION;
        4'd2:    k = K_LOGID;
        4'd3:    k = K_COMPAT;
        4'd4:    k = K_IRQ;
        4'd5:    k = K_DMA;
        4'd6:    k = K_STARTDEP;
        4'd7:    k = K_ENDDEP;
        4'd8:    k = K_IO;
        4'd9:    k = K_FIXEDIO;
        4'd14:   k = K_VENDOR;
        4'd15:   k = K_END;
        default: k = K_UNKNOWN;
      endcase
    end else begin
      unique case (h[6:0])
        7'd1:    k = K_MEM;
        7'd2:    k = K_ANSI;
        7'd3:    k = K_UNICODE;
        7'd4:    k = K_VENDOR;
        7'd5:    k = K_MEM32;
        7'd6:    k = K_FMEM32;
        default: k = K_UNKNOWN;
      endcase
    end
    return k;
  endfunction

endpackage

>>> src/pnp_prs_core.sv
// ----------------------------------------------------------------------------
// pnp_prs_core: parser state and per-byte record decode.
// Consumes one byte per cycle when step is high and forms at most one record.
// ----------------------------------------------------------------------------
module pnp_prs_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               start_req,
  output logic               rec_valid,
  output pnp_prs_pkg::rec_t  rec
);
  import pnp_prs_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [7:0]  lfsr, lfsr_next;
  logic [3:0]  serial_count, serial_count_next;
  logic [7:0]  tag_header, tag_header_next;
  logic [15:0] tag_length, tag_length_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] country_code, country_code_next;
  logic [7:0]  store [StoreDepth];
  logic        store_clr;
  logic        store_wr;
  logic [4:0]  store_idx;

  logic [2:0]  ph;
  logic [4:0]  hk;
  logic [4:0]  tk;
  logic [15:0] idx;
  logic [15:0] left_dec;
  logic        do_finish;
  logic [15:0] fin_len;
  rec_t        fin_rec;
  logic [7:0]  s [StoreDepth];

  // View of the store after this byte's write or clear, so finish sees the
  // final byte and a tag that closes at its header sees an empty store.
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      s[i] = store_clr ? 8'd0 : store[i];
      if (store_wr && store_idx == 5'(i)) s[i] = data_byte;
    end
  end

  always_comb begin
    ph = start_req ? PH_SERIAL : phase;
    hk = kind_of(data_byte);
    tk = kind_of(tag_header);
    idx = tag_length - bytes_left;
    left_dec = bytes_left - 16'd1;
    phase_next = ph;
    lfsr_next = start_req ? LfsrSeed : lfsr;
    serial_count_next = start_req ? 4'd0 : serial_count;
    tag_header_next = tag_header;
    tag_length_next = tag_length;
    bytes_left_next = bytes_left;
    country_code_next = country_code;
    store_clr = 1'b0;
    store_wr = 1'b0;
    store_idx = 5'd0;
    do_finish = 1'b0;
    fin_len = tag_length;
    rec_valid = 1'b0;
    rec = '0;
    unique case (ph)
      PH_SERIAL: begin
        if (serial_count_next < 4'd8) begin
          store_wr = 1'b1;
          store_idx = {2'b00, serial_count_next[2:0]};
          lfsr_next = lfsr_byte(lfsr_next, data_byte);
          serial_count_next = serial_count_next + 4'd1;
        end else if (data_byte == lfsr_next) begin
          phase_next = PH_TAG;
          rec_valid = 1'b1;
          rec.kind = K_HEADER;
          rec.value_a = {store[3], store[2], store[1], store[0]};
          rec.value_b = {store[7], store[6], store[5], store[4]};
        end else begin
          phase_next = PH_HALT;
          rec_valid = 1'b1;
          rec.kind = K_CSUM_ERR;
          rec.value_a = {24'd0, data_byte};
        end
      end
      PH_TAG: begin
        tag_header_next = data_byte;
        store_clr = 1'b1;
        country_code_next = '0;
        tag_length_next = '0;
        bytes_left_next = '0;
        if (hk == K_UNKNOWN) begin
          phase_next = PH_HALT;
          rec_valid = 1'b1;
          rec.kind = K_UNKNOWN;
          rec.value_a = {24'd0, data_byte};
        end else if (data_byte[7]) begin
          phase_next = PH_LEN_LO;
        end else begin
          tag_length_next = {13'd0, data_byte[2:0]};
          bytes_left_next = tag_length_next;
          fin_len = tag_length_next;
          if (data_byte[2:0] == 3'd0) do_finish = 1'b1;
          else phase_next = PH_BODY;
        end
      end
      PH_LEN_LO: begin
        tag_length_next = {8'd0, data_byte};
        phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        tag_length_next = {data_byte, tag_length[7:0]};
        bytes_left_next = tag_length_next;
        fin_len = tag_length_next;
        if (tag_length_next == 16'd0) do_finish = 1'b1;
        else phase_next = PH_BODY;
      end
      PH_BODY: begin
        bytes_left_next = left_dec;
        if (tk == K_VENDOR || tk == K_ANSI || (tk == K_UNICODE && idx >= 16'd2)) begin
          if (left_dec == 16'd0) phase_next = PH_TAG;
          rec_valid = 1'b1;
          rec.kind = tk;
          rec.value_a = {24'd0, data_byte};
          rec.value_b = (tk == K_UNICODE) ? {16'd0, country_code} : 32'd0;
          rec.has_byte = 1'b1;
          rec.last = (left_dec == 16'd0);
        end else begin
          if (tk == K_UNICODE) begin
            if (idx[0]) country_code_next[15:8] = data_byte;
            else country_code_next[7:0] = data_byte;
          end else if (idx < 16'(StoreDepth)) begin
            store_wr = 1'b1;
            store_idx = idx[4:0];
          end
          if (left_dec == 16'd0) do_finish = 1'b1;
        end
      end
      default: ;
    endcase

    // Record formed when any tag without per-byte records has all its bytes.
    fin_rec = '0;
    if (ph == PH_TAG) begin
      fin_rec.kind = hk;
    end else begin
      fin_rec.kind = tk;
    end
    unique case (fin_rec.kind)
      K_VERSION: begin
        fin_rec.value_a = {24'd0, s[0]};
        fin_rec.value_b = {24'd0, s[1]};
      end
      K_LOGID: begin
        fin_rec.flags = s[4];
        fin_rec.value_a = {s[3], s[2], s[1], s[0]};
        fin_rec.value_b = {24'd0, s[5]};
      end
      K_COMPAT: fin_rec.value_a = {s[3], s[2], s[1], s[0]};
      K_IRQ: begin
        fin_rec.flags = (fin_len > 16'd2) ? s[2] : 8'h01;
        fin_rec.value_a = {16'd0, s[1], s[0]};
      end
      K_DMA: begin
        fin_rec.flags = s[1];
        fin_rec.value_a = {24'd0, s[0]};
      end
      K_STARTDEP: fin_rec.value_a = {24'd0, s[0]};
      K_IO: begin
        fin_rec.flags = s[0];
        fin_rec.value_a = {16'd0, s[2], s[1]};
        fin_rec.value_b = {16'd0, s[4], s[3]};
        fin_rec.value_c = {24'd0, s[5]};
        fin_rec.value_d = {24'd0, s[6]};
      end
      K_FIXEDIO: begin
        fin_rec.value_a = {16'd0, s[1], s[0]};
        fin_rec.value_b = {24'd0, s[2]};
      end
      K_VENDOR, K_ANSI: fin_rec.last = 1'b1;
      K_UNICODE: begin
        fin_rec.value_b = {16'd0, country_code_next};
        fin_rec.last = 1'b1;
      end
      K_MEM: begin
        fin_rec.flags = s[0];
        fin_rec.value_a = {16'd0, s[2], s[1]};
        fin_rec.value_b = {16'd0, s[4], s[3]};
        fin_rec.value_c = {16'd0, s[6], s[5]};
        fin_rec.value_d = {16'd0, s[8], s[7]};
      end
      K_MEM32: begin
        fin_rec.flags = s[0];
        fin_rec.value_a = {s[4], s[3], s[2], s[1]};
        fin_rec.value_b = {s[8], s[7], s[6], s[5]};
        fin_rec.value_c = {s[12], s[11], s[10], s[9]};
        fin_rec.value_d = {s[16], s[15], s[14], s[13]};
      end
      K_FMEM32: begin
        fin_rec.flags = s[0];
        fin_rec.value_a = {s[4], s[3], s[2], s[1]};
        fin_rec.value_b = {s[8], s[7], s[6], s[5]};
      end
      K_END: fin_rec.value_a = {24'd0, s[0]};
      default: fin_rec.kind = K_ENDDEP;
    endcase

    if (do_finish) begin
      rec_valid = 1'b1;
      rec = fin_rec;
      phase_next = (fin_rec.kind == K_END) ? PH_HALT : PH_TAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SERIAL;
      lfsr <= LfsrSeed;
      serial_count <= '0;
      tag_header <= '0;
      tag_length <= '0;
      bytes_left <= '0;
      country_code <= '0;
    end else if (step) begin
      phase <= phase_next;
      lfsr <= lfsr_next;
      serial_count <= serial_count_next;
      tag_header <= tag_header_next;
      tag_length <= tag_length_next;
      bytes_left <= bytes_left_next;
      country_code <= country_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < StoreDepth; i++) begin
        if (store_clr) store[i] <= 8'd0;
        else if (store_wr && store_idx == 5'(i)) store[i] <= data_byte;
      end
    end
  end

endmodule

>>> src/pnp_card_resource_parser_unit.sv
// ----------------------------------------------------------------------------
// pnp_card_resource_parser_unit: ISA PnP card resource data parser.
// Registers each byte, decodes it against the parser state and emits records.
// ----------------------------------------------------------------------------
// Path: each byte waits in the input register, is decoded combinationally,
// and its record is captured in the output register.
// Throughput: one byte per cycle while the output register is free or
// draining; back-pressure on m_axis_tready stalls both registers.
// Reset (rst, synchronous, active high) empties both registers and puts the
// parser in serial collection with the LFSR at its 0x6A seed.
module pnp_card_resource_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // start_req
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // flags, value_a, value_b, value_c, value_d
  output logic [5:0]   m_axis_tuser,   // kind, has_byte
  output logic         m_axis_tlast    // last record of a variable-length item
);
  import pnp_prs_pkg::*;

  // Input register: one word in flight into the decoder.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_full;
  logic       adv;
  logic       rec_valid;
  rec_t       rec;
  rec_t       out_rec;

  // The decoder advances whenever the output register is free or draining.
  assign adv = !out_full || m_axis_tready;
  assign s_axis_tready = adv || !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  pnp_prs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_valid && adv),
    .data_byte (in_byte),
    .start_req (in_start),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (adv) begin
      out_full <= in_valid && rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rec <= rec;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = {out_rec.value_d, out_rec.value_c, out_rec.value_b,
                         out_rec.value_a, out_rec.flags};
  assign m_axis_tuser = {out_rec.has_byte, out_rec.kind};
  assign m_axis_tlast = out_rec.last;

endmodule
